### hw/rtl/ostt_pkg.sv
// shared types and codes of the one-shot timer table
`default_nettype none
package ostt_pkg;

   // item operation codes
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_CANCEL   = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // result kinds
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   // field widths
   localparam int TIME_WIDTH   = 48;
   localparam int ID_WIDTH     = 32;
   localparam int HANDLE_WIDTH = 16;
   localparam int DELAY_WIDTH  = 32;

   // at most this many timers fire on one tick
   localparam int                COUNT_WIDTH = 7;
   localparam logic [COUNT_WIDTH-1:0] FIRE_LIMIT = 7'd64;

   // command walking down the row of slots
   typedef struct packed {
      logic                    valid;
      logic [1:0]              op;
      logic                    done;
      logic [COUNT_WIDTH-1:0]  count;
      logic [ID_WIDTH-1:0]     id;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [TIME_WIDTH-1:0]   deadline;
   } packet_type;

   // expired timer reported by a slot
   typedef struct packed {
      logic                    valid;
      logic [ID_WIDTH-1:0]     id;
      logic [HANDLE_WIDTH-1:0] handle;
   } fire_type;

endpackage
`default_nettype wire

### hw/rtl/ostt_cell.sv
// one timer slot: holds an entry and acts on the passing command
`default_nettype none
module ostt_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              hold,
   input  wire logic [ostt_pkg::TIME_WIDTH-1:0]   time_now,
   input  wire ostt_pkg::packet_type              pkt_in,
   output ostt_pkg::packet_type                   pkt_out,
   output ostt_pkg::fire_type                     fire
);
   import ostt_pkg::*;

   logic                    active_ff;
   logic                    active_in;
   logic [TIME_WIDTH-1:0]   deadline_ff;
   logic [ID_WIDTH-1:0]     id_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   packet_type              pkt_ff;
   packet_type              pkt_in_next;
   logic                    sched_hit;
   logic                    cancel_hit;
   logic                    fire_hit;

   // decide what this slot does with the command
   always_comb begin
      sched_hit  = pkt_in.valid && (pkt_in.op == OP_SCHEDULE) && !pkt_in.done && !active_ff;
      cancel_hit = pkt_in.valid && (pkt_in.op == OP_CANCEL) && !pkt_in.done && active_ff
                   && (id_ff == pkt_in.id);
      fire_hit   = pkt_in.valid && (pkt_in.op == OP_TICK) && active_ff
                   && (deadline_ff <= time_now) && (pkt_in.count < FIRE_LIMIT);

      pkt_in_next = pkt_in;
      if (sched_hit || cancel_hit) begin
         pkt_in_next.done = 1'b1;
      end
      if (fire_hit) begin
         pkt_in_next.count = pkt_in.count + 7'd1;
      end

      active_in = active_ff;
      if (sched_hit) begin
         active_in = 1'b1;
      end else if (cancel_hit || fire_hit) begin
         active_in = 1'b0;
      end

      fire.valid  = fire_hit;
      fire.id     = fire_hit ? id_ff : '0;
      fire.handle = fire_hit ? handle_ff : '0;
   end

   // slot state and command stage
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pkt_ff    <= '0;
      end else if (!hold) begin
         active_ff <= active_in;
         pkt_ff    <= pkt_in_next;
      end
   end

   // entry payload, written when the slot is claimed
   always_ff @(posedge clock) begin
      if (!hold && sched_hit) begin
         deadline_ff <= pkt_in.deadline;
         id_ff       <= pkt_in.id;
         handle_ff   <= pkt_in.handle;
      end
   end

   assign pkt_out = pkt_ff;

endmodule
`default_nettype wire

### hw/rtl/one_shot_timer_table_unit.sv
// top level of the one-shot timer table: entry, slot row and result staging
//
// req_ channel takes one item: op (schedule, cancel, tick), delay, handle and
// cancel_id. rsp_ channel gives results: kind, status, task_id, fired_handle
// and last, which marks the final result of an item.
// Schedule and cancel each give one reply. A tick gives one fired result per
// expired timer, in slot order, and nothing if none expired. Op 3 gives none.
// Items are taken one at a time. An accepted item enters a command register
// and walks the row of TABLE_DEPTH slots one slot per cycle while the row is
// not held; its final result, if any, is presented in the same cycle in which
// req_ready rises again. Fired results stage in a one-entry holding register
// so the last flag can be set at the end of row.
// A stalled receiver freezes the whole row and holds the output register.
// Reset frees all slots, clears time to zero and sets the next id to one;
// no clearing pass is needed.
`default_nettype none
module one_shot_timer_table_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_op,
   input  wire logic [ostt_pkg::DELAY_WIDTH-1:0]    req_delay,
   input  wire logic [ostt_pkg::HANDLE_WIDTH-1:0]   req_handle,
   input  wire logic [ostt_pkg::ID_WIDTH-1:0]       req_cancel_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_kind,
   output logic [1:0]                               rsp_status,
   output logic [ostt_pkg::ID_WIDTH-1:0]            rsp_task_id,
   output logic [ostt_pkg::HANDLE_WIDTH-1:0]        rsp_fired_handle,
   output logic                                     rsp_last
);
   import ostt_pkg::*;

   packet_type              chain [TABLE_DEPTH+1];
   fire_type                fires [TABLE_DEPTH];
   packet_type              entry_ff;
   packet_type              entry_in;
   logic                    busy_ff;
   logic [TIME_WIDTH-1:0]   time_now_ff;
   logic [ID_WIDTH-1:0]     next_id_ff;
   logic                    pend_valid_ff;
   logic [ID_WIDTH-1:0]     pend_id_ff;
   logic [HANDLE_WIDTH-1:0] pend_handle_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [1:0]              rsp_status_ff;
   logic [ID_WIDTH-1:0]     rsp_task_id_ff;
   logic [HANDLE_WIDTH-1:0] rsp_fired_handle_ff;
   logic                    rsp_last_ff;
   logic                    accept;
   fire_type                fire_any;
   packet_type              tail;
   logic                    tail_reply;
   logic                    tail_flush;
   logic                    sched_ok;
   logic                    out_free;
   logic                    hold;
   logic                    push;
   logic                    push_kind;
   logic [1:0]              push_status;
   logic [ID_WIDTH-1:0]     push_id;
   logic [HANDLE_WIDTH-1:0] push_handle;
   logic                    push_last;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;

   // build the command for an accepted item
   always_comb begin
      entry_in.valid    = 1'b1;
      entry_in.op       = req_op;
      entry_in.done     = (req_op == OP_SCHEDULE) && (req_handle == '0);
      entry_in.count    = '0;
      entry_in.id       = (req_op == OP_CANCEL) ? req_cancel_id : next_id_ff;
      entry_in.handle   = req_handle;
      entry_in.deadline = time_now_ff + {{(TIME_WIDTH-DELAY_WIDTH){1'b0}}, req_delay};
   end

   assign chain[0] = entry_ff;

   // row of timer slots
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_slot
      ostt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .hold     (hold),
         .time_now (time_now_ff),
         .pkt_in   (chain[g]),
         .pkt_out  (chain[g+1]),
         .fire     (fires[g])
      );
   end

   // gather the single firing slot, if any
   always_comb begin
      fire_any = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fire_any.valid  = fire_any.valid | fires[i].valid;
         fire_any.id     = fire_any.id | fires[i].id;
         fire_any.handle = fire_any.handle | fires[i].handle;
      end
   end

   // end of row and output staging
   always_comb begin
      tail       = chain[TABLE_DEPTH];
      tail_reply = tail.valid && ((tail.op == OP_SCHEDULE) || (tail.op == OP_CANCEL));
      tail_flush = tail.valid && (tail.op == OP_TICK) && pend_valid_ff;
      sched_ok   = tail.done && (tail.handle != '0);
      out_free   = !rsp_valid_ff || rsp_ready;

      push        = 1'b0;
      push_kind   = KIND_REPLY;
      push_status = STATUS_OK;
      push_id     = '0;
      push_handle = '0;
      push_last   = 1'b1;
      if (fire_any.valid && pend_valid_ff) begin
         push        = 1'b1;
         push_kind   = KIND_FIRED;
         push_id     = pend_id_ff;
         push_handle = pend_handle_ff;
         push_last   = 1'b0;
      end else if (tail_reply) begin
         push = 1'b1;
         if (tail.op == OP_CANCEL) begin
            push_status = tail.done ? STATUS_OK : STATUS_NOT_FOUND;
            push_id     = tail.id;
         end else if (tail.handle == '0) begin
            push_status = STATUS_INVALID;
         end else if (sched_ok) begin
            push_id = tail.id;
         end else begin
            push_status = STATUS_FULL;
         end
      end else if (tail_flush) begin
         push        = 1'b1;
         push_kind   = KIND_FIRED;
         push_id     = pend_id_ff;
         push_handle = pend_handle_ff;
      end

      hold = push && !out_free;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         entry_ff      <= '0;
         time_now_ff   <= '0;
         next_id_ff    <= {{(ID_WIDTH-1){1'b0}}, 1'b1};
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (tail.valid && !hold) begin
            busy_ff <= 1'b0;
         end

         if (!hold) begin
            entry_ff <= accept ? entry_in : '0;
         end

         if (accept && (req_op == OP_TICK)) begin
            time_now_ff <= time_now_ff + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
         end

         if (!hold && tail.valid && (tail.op == OP_SCHEDULE) && sched_ok) begin
            next_id_ff <= (next_id_ff == '1) ? {{(ID_WIDTH-1){1'b0}}, 1'b1}
                                             : next_id_ff + {{(ID_WIDTH-1){1'b0}}, 1'b1};
         end

         if (!hold) begin
            if (fire_any.valid) begin
               pend_valid_ff <= 1'b1;
            end else if (tail_flush) begin
               pend_valid_ff <= 1'b0;
            end
         end

         if (out_free) begin
            rsp_valid_ff <= push;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!hold && fire_any.valid) begin
         pend_id_ff     <= fire_any.id;
         pend_handle_ff <= fire_any.handle;
      end
      if (push && out_free) begin
         rsp_kind_ff         <= push_kind;
         rsp_status_ff       <= push_status;
         rsp_task_id_ff      <= push_id;
         rsp_fired_handle_ff <= push_handle;
         rsp_last_ff         <= push_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_task_id      = rsp_task_id_ff;
   assign rsp_fired_handle = rsp_fired_handle_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire
